// File: sv/gyif_pkg.sv
// Shared constants and types for the gyro yaw integrator with GPS fusion.
package gyif_pkg;

  // Angles are fixed point in 2^-ANGLE_FRAC_BITS degree.
  localparam int ANGLE_FRAC_BITS = 24;

  localparam int H_W    = 34;  // wrapped, reset, IMU and fused headings
  localparam int T_W    = 48;  // unbounded total heading
  localparam int STEP_W = 32;  // saturated yaw step

  // Degree constants in angle units, kept at 64 bits for the range checks.
  localparam longint D180 = longint'(180) <<< ANGLE_FRAC_BITS;
  localparam longint D360 = longint'(360) <<< ANGLE_FRAC_BITS;

  // GPS course arrives in 2^-16 degree.
  localparam int         GPS_SHIFT = ANGLE_FRAC_BITS - 16;
  localparam logic [24:0] GPS_HALF = 25'(180 * 65536);
  localparam logic [25:0] GPS_FULL = 26'(360 * 65536);

  // Blend accumulator width: covers both weighted products plus rounding.
  localparam int GPS_W = 26 + GPS_SHIFT;
  localparam int ACC_W = (GPS_W + 20 > 54) ? GPS_W + 20 : 54;

  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic [15:0] ROUND_HALF = 16'd32768;

  // Register map, one 32-bit word per register.
  typedef enum logic [2:0] {
    REG_ZERO_RATE    = 3'd0,
    REG_DEADBAND     = 3'd1,
    REG_STEP_GAIN    = 3'd2,
    REG_SPEED_THRESH = 3'd3,
    REG_IMU_WEIGHT   = 3'd4
  } cfg_reg_t;

  // Work handed from the precompute stage to the state update stage.
  typedef struct packed {
    logic                     kind;
    logic                     apply;
    logic                     fuse;
    logic signed [STEP_W-1:0] step;
    logic signed [ACC_W-1:0]  gps_term;
  } pre_t;

endpackage

// File: sv/gyro_yaw_integrator_fusion.sv
// Top level of the gyro yaw integrator with GPS complementary fusion.
//
// Every input request is either a gyro tick (in_tuser low) or a fusion tick (in_tuser high)
// and produces exactly one result request holding the wrapped, reset, total and IMU headings
// after that tick. The block takes one request per clock as long as out_tready does not hold
// results back. A request passes through the input register, then the precompute register
// that holds the saturated gyro step and the weighted GPS term, then the heading registers
// that double as the result register. The recurrence through the heading registers, which
// contains the IMU-weight multiply of the blend, is what sets the one-per-clock rate.
// Configuration registers sit on the APB port at byte addresses 0, 4, 8, 12 and 16 and are
// meant to be written only while no request is in flight.
module gyro_yaw_integrator_fusion
  import gyif_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,

  input  logic         in_tvalid,
  output logic         in_tready,
  // [15:0] gyro_raw, [40:16] gps_heading, [56:41] wheel_speed, [63:57] zero
  input  logic [63:0]  in_tdata,
  // [0] kind
  input  logic         in_tuser,

  output logic         out_tvalid,
  input  logic         out_tready,
  // [33:0] heading_wrapped, [67:34] heading_reset, [115:68] heading_total,
  // [149:116] imu_heading, [151:150] zero
  output logic [151:0] out_tdata,
  // [0] fusion_active
  output logic         out_tuser,

  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic signed [15:0] zero_rate_r;
  logic [14:0]        deadband_r;
  logic [15:0]        step_gain_r;
  logic signed [15:0] speed_thresh_r;
  logic [16:0]        imu_weight_r;

  cfg_reg_t cfg_idx;
  logic     cfg_wr;

  assign cfg_idx    = cfg_reg_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_rate_r    <= '0;
      deadband_r     <= 15'd14;
      step_gain_r    <= 16'd5115;
      speed_thresh_r <= 16'sd100;
      imu_weight_r   <= 17'd52429;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ZERO_RATE:    zero_rate_r    <= cfg_pwdata[15:0];
        REG_DEADBAND:     deadband_r     <= cfg_pwdata[14:0];
        REG_STEP_GAIN:    step_gain_r    <= cfg_pwdata[15:0];
        REG_SPEED_THRESH: speed_thresh_r <= cfg_pwdata[15:0];
        REG_IMU_WEIGHT:   imu_weight_r   <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ZERO_RATE:    cfg_prdata = {16'd0, zero_rate_r};
      REG_DEADBAND:     cfg_prdata = {17'd0, deadband_r};
      REG_STEP_GAIN:    cfg_prdata = {16'd0, step_gain_r};
      REG_SPEED_THRESH: cfg_prdata = {16'd0, speed_thresh_r};
      REG_IMU_WEIGHT:   cfg_prdata = {15'd0, imu_weight_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // Weight above one counts as one.
  logic [16:0] wi;
  assign wi = (imu_weight_r > WEIGHT_ONE) ? WEIGHT_ONE : imu_weight_r;

  // ------------------------------------------------------------------
  // Flow control: each stage loads when it is empty or its content moves on.
  // ------------------------------------------------------------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic rdy_out, rdy_s2, rdy_s1;

  assign rdy_out   = !out_v_r || out_tready;
  assign rdy_s2    = !s2_v_r || rdy_out;
  assign rdy_s1    = !s1_v_r || rdy_s2;
  assign in_tready = rdy_s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy_s1)  s1_v_r  <= in_tvalid;
      if (rdy_s2)  s2_v_r  <= s1_v_r;
      if (rdy_out) out_v_r <= s2_v_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: input register
  // ------------------------------------------------------------------
  logic               s1_kind_r;
  logic signed [15:0] s1_raw_r;
  logic [24:0]        s1_gps_r;
  logic signed [15:0] s1_speed_r;

  always_ff @(posedge clk) begin
    if (rdy_s1) begin
      s1_kind_r  <= in_tuser;
      s1_raw_r   <= in_tdata[15:0];
      s1_gps_r   <= in_tdata[40:16];
      s1_speed_r <= in_tdata[56:41];
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: gyro step and the GPS side of the blend, both free of state
  // ------------------------------------------------------------------
  logic signed [16:0]     diff;
  logic [16:0]            mag;
  logic signed [33:0]     prod;
  logic signed [STEP_W-1:0] step_sat;
  logic [16:0]            gps_w;
  logic signed [25:0]     g16;
  logic signed [43:0]     gps_prod;
  pre_t                   pre_nxt, pre_r;

  always_comb begin
    diff = {s1_raw_r[15], s1_raw_r} - {zero_rate_r[15], zero_rate_r};
    mag  = diff[16] ? 17'(-diff) : 17'(diff);
    prod = $signed(diff) * $signed({1'b0, step_gain_r});
    // Saturate the product to 32-bit signed.
    if (prod[33:31] == 3'b000 || prod[33:31] == 3'b111) begin
      step_sat = prod[31:0];
    end else if (prod[33]) begin
      step_sat = {1'b1, {(STEP_W-1){1'b0}}};
    end else begin
      step_sat = {1'b0, {(STEP_W-1){1'b1}}};
    end

    // Courses above 180 degrees fold to negative angles.
    g16      = (s1_gps_r > GPS_HALF) ? ($signed({1'b0, s1_gps_r}) - $signed(GPS_FULL))
                                     : $signed({1'b0, s1_gps_r});
    gps_w    = WEIGHT_ONE - wi;
    gps_prod = g16 * $signed({1'b0, gps_w});

    pre_nxt.kind     = s1_kind_r;
    pre_nxt.apply    = mag > {2'b00, deadband_r};
    pre_nxt.fuse     = s1_speed_r > speed_thresh_r;
    pre_nxt.step     = step_sat;
    pre_nxt.gps_term = (ACC_W'(gps_prod) <<< GPS_SHIFT)
                     + $signed({{(ACC_W-16){1'b0}}, ROUND_HALF});
  end

  always_ff @(posedge clk) begin
    if (rdy_s2) pre_r <= pre_nxt;
  end

  // ------------------------------------------------------------------
  // Stage 3: heading state, which is also the result register
  // ------------------------------------------------------------------
  function automatic logic signed [H_W-1:0] sat_h(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi, lo;
    hi = ACC_W'({1'b0, {(H_W-1){1'b1}}});
    lo = -hi - ACC_W'(1);
    if (v > hi) return hi[H_W-1:0];
    if (v < lo) return lo[H_W-1:0];
    return v[H_W-1:0];
  endfunction

  function automatic logic signed [T_W-1:0] sat_t(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi, lo;
    hi = ACC_W'({1'b0, {(T_W-1){1'b1}}});
    lo = -hi - ACC_W'(1);
    if (v > hi) return hi[T_W-1:0];
    if (v < lo) return lo[T_W-1:0];
    return v[T_W-1:0];
  endfunction

  function automatic logic beyond_360(input logic signed [H_W-1:0] v);
    return (64'(v) > D360) || (64'(v) < -D360);
  endfunction

  logic signed [H_W-1:0] yaw_wrapped_r, yaw_reset_r, yaw_imu_r, yaw_fused_r;
  logic signed [T_W-1:0] yaw_total_r;
  logic                  fused_mode_r;
  logic signed [STEP_W-1:0] last_step_r;

  logic signed [H_W-1:0] yaw_wrapped_nxt, yaw_reset_nxt, yaw_imu_nxt, yaw_fused_nxt;
  logic signed [T_W-1:0] yaw_total_nxt;
  logic                  fused_mode_nxt;
  logic signed [STEP_W-1:0] last_step_nxt;

  logic signed [H_W-1:0]   w_sat, r_sat, base, n_sat, f_val;
  logic signed [63:0]      w_long;
  logic signed [ACC_W-1:0] acc;

  always_comb begin
    yaw_wrapped_nxt = yaw_wrapped_r;
    yaw_reset_nxt   = yaw_reset_r;
    yaw_total_nxt   = yaw_total_r;
    yaw_imu_nxt     = yaw_imu_r;
    yaw_fused_nxt   = yaw_fused_r;
    fused_mode_nxt  = fused_mode_r;
    last_step_nxt   = last_step_r;

    // Gyro path: clockwise counts positive, so the step is subtracted.
    w_sat  = sat_h(ACC_W'(yaw_wrapped_r) - ACC_W'(pre_r.step));
    w_long = 64'(w_sat);
    r_sat  = sat_h(ACC_W'(yaw_reset_r) - ACC_W'(pre_r.step));

    // Fusion path.
    acc   = $signed(ACC_W'({1'b0, wi})) * ACC_W'(yaw_imu_r) + pre_r.gps_term;
    f_val = sat_h(acc >>> 16);
    // Leaving fusion restarts the IMU heading from the fused one.
    base  = fused_mode_r ? yaw_fused_r : yaw_imu_r;
    n_sat = sat_h(ACC_W'(base) - ACC_W'(last_step_r));

    if (!pre_r.kind) begin
      last_step_nxt = pre_r.step;
      if (pre_r.apply) begin
        if (w_long > D180 && w_long <= D360) begin
          yaw_wrapped_nxt = H_W'(w_long - D360);
        end else if (w_long < -D180 && w_long >= -D360) begin
          yaw_wrapped_nxt = H_W'(w_long + D360);
        end else begin
          yaw_wrapped_nxt = w_sat;
        end
        yaw_reset_nxt = beyond_360(r_sat) ? '0 : r_sat;
        yaw_total_nxt = sat_t(ACC_W'(yaw_total_r) - ACC_W'(pre_r.step));
      end
    end else if (pre_r.fuse) begin
      yaw_fused_nxt   = f_val;
      fused_mode_nxt  = 1'b1;
      yaw_wrapped_nxt = f_val;
    end else begin
      fused_mode_nxt  = 1'b0;
      yaw_imu_nxt     = beyond_360(n_sat) ? '0 : n_sat;
      yaw_wrapped_nxt = beyond_360(n_sat) ? '0 : n_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_wrapped_r <= '0;
      yaw_reset_r   <= '0;
      yaw_total_r   <= '0;
      yaw_imu_r     <= '0;
      yaw_fused_r   <= '0;
      fused_mode_r  <= 1'b0;
      last_step_r   <= '0;
    end else if (rdy_out && s2_v_r) begin
      yaw_wrapped_r <= yaw_wrapped_nxt;
      yaw_reset_r   <= yaw_reset_nxt;
      yaw_total_r   <= yaw_total_nxt;
      yaw_imu_r     <= yaw_imu_nxt;
      yaw_fused_r   <= yaw_fused_nxt;
      fused_mode_r  <= fused_mode_nxt;
      last_step_r   <= last_step_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, yaw_imu_r, yaw_total_r, yaw_reset_r, yaw_wrapped_r};
  assign out_tuser  = fused_mode_r;

endmodule
